>>> sv/rtk_pkg.sv
package rtk_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int DIGIT_W = 8;
    localparam int FANOUT  = 256;

    localparam int LEVELS_DEF    = 4;
    localparam int NODE_POOL_DEF = 256;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET    = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] found_value;
        logic             status;
    } res_t;

endpackage

>>> sv/rtk_mem.sv
module rtk_mem
    import rtk_pkg::*;
#(
    parameter int NODE_POOL = NODE_POOL_DEF
)
(
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [$clog2(NODE_POOL)+DIGIT_W-1:0]       waddr,
    input  logic [VAL_W-1:0]                           wdata,
    input  logic                                       re,
    input  logic [$clog2(NODE_POOL)+DIGIT_W-1:0]       raddr,
    output logic [VAL_W-1:0]                           rdata
);

    localparam int DEPTH = NODE_POOL * FANOUT;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rtk_ctrl.sv
module rtk_ctrl
    import rtk_pkg::*;
#(
    parameter int LEVELS    = LEVELS_DEF,
    parameter int NODE_POOL = NODE_POOL_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [MODE_W-1:0]                      in_mode,
    input  logic [KEY_W-1:0]                       in_key,
    input  logic [VAL_W-1:0]                       in_value,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output res_t                                   res,
    output logic                                   mem_we,
    output logic [$clog2(NODE_POOL)+DIGIT_W-1:0]   mem_waddr,
    output logic [VAL_W-1:0]                       mem_wdata,
    output logic                                   mem_re,
    output logic [$clog2(NODE_POOL)+DIGIT_W-1:0]   mem_raddr,
    input  logic [VAL_W-1:0]                       mem_rdata
);

    localparam int NW    = $clog2(NODE_POOL);
    localparam int NFW   = $clog2(NODE_POOL + 1);
    localparam int AW    = NW + DIGIT_W;
    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = NODE_POOL * FANOUT;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [NFW-1:0]     nf_reg, nf_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    mode_t              mode_reg, mode_next;
    logic [NW-1:0]      node_reg, node_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    res_t               res_reg, res_next;
    logic [DIGIT_W-1:0] digit_reg [LEVELS];
    logic [DIGIT_W-1:0] digit_next [LEVELS];
    logic [DIGIT_W-1:0] digit_in [LEVELS];

    logic [LW-1:0]      lvl_inc;
    logic               is_leaf;
    logic               child_ok;
    logic [NW-1:0]      child;
    logic [LW-1:0]      need;
    logic [NFW-1:0]     remaining;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            digit_in[i] = DIGIT_W'(64'(in_key) >> (DIGIT_W * (LEVELS - 1 - i)));
        end
    end

    assign lvl_inc   = lvl_reg + 1'b1;
    assign is_leaf   = (lvl_reg == LW'(LEVELS - 1));
    assign child     = mem_rdata[NW-1:0];
    // Slot contents outside the pool, or node zero, mean no child.
    assign child_ok  = (mem_rdata < VAL_W'(NODE_POOL)) && (child != '0);
    assign need      = LW'(LEVELS - 1) - lvl_reg;
    assign remaining = NFW'(NODE_POOL) - nf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            nf_reg    <= NFW'(1);
            lvl_reg   <= '0;
            mode_reg  <= MODE_SET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nf_reg    <= nf_next;
            lvl_reg   <= lvl_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        value_reg <= value_next;
        res_reg   <= res_next;
        for (int i = 0; i < LEVELS; i++)
        begin
            digit_reg[i] <= digit_next[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        nf_next    = nf_reg;
        lvl_next   = lvl_reg;
        mode_next  = mode_reg;
        node_next  = node_reg;
        value_next = value_reg;
        res_next   = res_reg;
        for (int i = 0; i < LEVELS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode_t'(in_mode);
                    value_next = (in_mode == MODE_DELETE) ? '0 : in_value;
                    lvl_next   = '0;
                    node_next  = '0;
                    res_next   = '0;
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        digit_next[i] = digit_in[i];
                    end
                    if (in_mode == MODE_SET || in_mode == MODE_LOOKUP ||
                        in_mode == MODE_DELETE)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = {NW'(0), digit_in[0]};
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_READ:
            begin
                if (is_leaf)
                begin
                    res_next.found_value = mem_rdata;
                    state_next           = ST_RESP;
                end
                else if (!child_ok)
                begin
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (32'(need) > 32'(remaining))
                    begin
                        // Not enough nodes left for the rest of the path.
                        res_next.status = 1'b1;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else
                begin
                    node_next = child;
                    lvl_next  = lvl_inc;
                    if (mode_reg != MODE_LOOKUP && lvl_inc == LW'(LEVELS - 1))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = {child, digit_reg[lvl_inc]};
                    end
                end
            end

            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = {node_reg, digit_reg[lvl_reg]};
                if (is_leaf)
                begin
                    mem_wdata  = value_reg;
                    state_next = ST_RESP;
                end
                else
                begin
                    // Link a fresh node; it was cleared after reset and never used.
                    mem_wdata = VAL_W'(nf_reg);
                    node_next = nf_reg[NW-1:0];
                    nf_next   = nf_reg + 1'b1;
                    lvl_next  = lvl_inc;
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

>>> sv/radix_trie_key_value_map.sv
// Channel   Direction  tdata                          tuser
// s_axis    in         key [31:0], value [63:32]      mode [1:0]
// m_axis    out        found_value [31:0]             status [0]
//
// One item is in work at a time. A lookup makes one dependent node memory read per trie
// level; a set or delete makes one write per allocated node plus the leaf write, and
// mode three makes no memory access. The next item is accepted in the cycle after the
// result enters the output register, while that result waits in the output register.
// After reset the node memory is cleared before the first item is accepted.
module radix_trie_key_value_map
    import rtk_pkg::*;
#(
    parameter int LEVELS    = LEVELS_DEF,
    parameter int NODE_POOL = NODE_POOL_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // found_value [31:0]
    output logic [0:0]  m_axis_tuser    // status [0]
);

    localparam int AW = $clog2(NODE_POOL) + DIGIT_W;

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    rtk_ctrl #(
        .LEVELS    (LEVELS),
        .NODE_POOL (NODE_POOL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_key    (s_axis_tdata[31:0]),
        .in_value  (s_axis_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    rtk_mem #(
        .NODE_POOL (NODE_POOL)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a result when it is empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.found_value;
    assign m_axis_tuser  = out_reg.status;

endmodule

>>> tb/sv/trie_map_checker.sv
module trie_map_checker
    import rtk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // found_value [31:0]
    input  logic [0:0]  m_axis_tuser,   // status [0]
    output int          error_count,
    output int          due_count
);

    localparam int LEVELS    = LEVELS_DEF;
    localparam int NODE_POOL = NODE_POOL_DEF;

    logic [VAL_W-1:0] node_words [NODE_POOL*FANOUT];
    int unsigned      free_node;
    res_t             due_answers [$];
    int               mismatches;

    function automatic int unsigned key_digit(logic [KEY_W-1:0] key, int lvl);
        return (key >> (DIGIT_W * (LEVELS - 1 - lvl))) % FANOUT;
    endfunction

    // A child number outside the pool reads as no child at all.
    function automatic int unsigned child_node(int unsigned node, int unsigned digit);
        int unsigned c;
        c = node_words[node * FANOUT + digit];
        return (c < NODE_POOL) ? c : 0;
    endfunction

    function automatic logic [VAL_W-1:0] lookup_value(logic [KEY_W-1:0] key);
        int unsigned node;
        int          lvl;
        node = 0;
        for (lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            node = child_node(node, key_digit(key, lvl));
            if (node == 0)
                return '0;
        end
        return node_words[node * FANOUT + key_digit(key, LEVELS - 1)];
    endfunction

    // Returns the status bit: one when the pool cannot hold the new path.
    function automatic logic store_value(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int unsigned node;
        int unsigned c;
        int unsigned need;
        int          lvl;
        int          slot;
        node = 0;
        need = 0;
        for (lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            node = child_node(node, key_digit(key, lvl));
            if (node == 0)
            begin
                need = LEVELS - 1 - lvl;
                break;
            end
        end
        // The whole path is checked before anything is allocated.
        if (free_node > NODE_POOL || need > NODE_POOL - free_node)
            return 1'b1;
        node = 0;
        for (lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            c = child_node(node, key_digit(key, lvl));
            if (c == 0)
            begin
                c = free_node;
                free_node++;
                for (slot = 0; slot < FANOUT; slot++)
                    node_words[c * FANOUT + slot] = '0;
                node_words[node * FANOUT + key_digit(key, lvl)] = c;
            end
            node = c;
        end
        node_words[node * FANOUT + key_digit(key, LEVELS - 1)] = value;
        return 1'b0;
    endfunction

    function automatic res_t predict_access(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] value);
        res_t r;
        r = '0;
        case (mode)
            MODE_SET:    r.status = store_value(key, value);
            MODE_DELETE: r.status = store_value(key, '0);
            MODE_LOOKUP: r.found_value = lookup_value(key);
            default:     ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            foreach (node_words[i])
                node_words[i] = '0;
            free_node = 1;
            due_answers.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: found_value %h status %0d",
                                 m_axis_tdata, m_axis_tuser[0]);
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (m_axis_tdata !== want.found_value || m_axis_tuser[0] !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: found_value %h expected %h, status %0d expected %0d",
                                     m_axis_tdata, want.found_value, m_axis_tuser[0], want.status);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_answers.push_back(predict_access(s_axis_tuser, s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32]));
        end
        error_count <= mismatches;
        due_count   <= due_answers.size();
    end

endmodule

>>> tb/sv/radix_trie_key_value_map_test.sv
module radix_trie_key_value_map_test;
    import rtk_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1680;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int          error_count;
    int          due_count;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    logic [7:0]  hot_top [4];
    logic [7:0]  hot_mid [4];
    logic [7:0]  hot_low [4];
    logic [31:0] known_keys [$];

    always #10 clk = ~clk;

    radix_trie_key_value_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    trie_map_checker map_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .due_count     (due_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Valid stays high across back-to-back transfers; it only drops for a gap or while draining.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [31:0] key, logic [31:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= mode;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    // Most keys share a few prefixes so the pool lasts well into the run;
    // fully random keys eat three nodes each and exhaust it eventually.
    function automatic logic [31:0] pick_key();
        int unsigned sel;
        logic [31:0] key;
        sel = $urandom_range(0, 99);
        key = $urandom;
        if (sel < 20 && known_keys.size() > 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (sel < 85)
        begin
            key[31:24] = hot_top[$urandom_range(0, 3)];
            key[23:16] = hot_mid[$urandom_range(0, 3)];
        end
        if (sel < 75)
            key[15:8] = hot_low[$urandom_range(0, 3)];
        return key;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        logic [MODE_W-1:0] mode;
        logic [31:0]       key;
        logic [31:0]       rnd;
        int unsigned       sel;
        int                i;

        hot_top[0] = 8'h00;
        hot_top[1] = 8'hFF;
        hot_mid[0] = 8'h00;
        hot_mid[1] = 8'hFF;
        hot_low[0] = 8'h00;
        hot_low[1] = 8'hFF;
        for (i = 2; i < 4; i++)
        begin
            rnd = $urandom;
            hot_top[i] = rnd[7:0];
            hot_mid[i] = rnd[15:8];
            hot_low[i] = rnd[23:16];
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty trie, extremes of key and value, shared and missing paths.
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_SET,    32'h0000_0000, 32'hFFFF_FFFF);
        send_item(MODE_SET,    32'hFFFF_FFFF, 32'h0000_0001);
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_SET,    32'h0000_0001, 32'h8000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(MODE_LOOKUP, 32'h0000_0002, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0001_0000, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_DELETE, 32'h1234_5678, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_SET,    32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
        send_item(MODE_SET,    32'hA5A5_A5A5, 32'h0000_0000);
        send_item(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i % 300) >= 240;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 40)
                mode = MODE_SET;
            else if (sel < 75)
                mode = MODE_LOOKUP;
            else if (sel < 93)
                mode = MODE_DELETE;
            else
                mode = MODE_UNUSED;
            key = pick_key();
            if (mode == MODE_LOOKUP && $urandom_range(0, 1) == 1 && known_keys.size() > 0)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            if (mode == MODE_SET)
            begin
                known_keys.push_back(key);
                if (known_keys.size() > 64)
                    void'(known_keys.pop_front());
            end
            send_item(mode, key, pick_value());
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
